[hw/rtl/ep2t_pkg.sv]
// ----------------------------------------------------------------------------
// ep2t_pkg
// shared widths, cordic constants and helpers for the pose to transform block
// ----------------------------------------------------------------------------
`default_nettype none
package ep2t_pkg;
  localparam int AngleBits  = 16;
  localparam int CoefBits   = 16;
  localparam int PosBits    = 32;
  localparam int CordSteps  = 24;
  localparam int CordW      = 34;   // q1.30 plus growth headroom
  localparam int ZW         = 33;
  localparam int CoefF      = CoefBits - 2;
  localparam int ProdW      = 2 * CordW;
  localparam int SumW       = CordW + 2;

  localparam logic signed [CordW-1:0] CordGain = CordW'(64'sd652032874);

  typedef logic signed [CordW-1:0] cval_t;
  typedef logic signed [ZW-1:0]    zval_t;
  typedef logic signed [SumW-1:0]  sval_t;

  function automatic zval_t atan_tab(input logic [4:0] i);
    zval_t r;
    case (i)
      5'd0:  r = ZW'(32'h20000000);
      5'd1:  r = ZW'(32'h12E4051E);
      5'd2:  r = ZW'(32'h09FB385B);
      5'd3:  r = ZW'(32'h051111D4);
      5'd4:  r = ZW'(32'h028B0D43);
      5'd5:  r = ZW'(32'h0145D7E1);
      5'd6:  r = ZW'(32'h00A2F61E);
      5'd7:  r = ZW'(32'h00517C55);
      5'd8:  r = ZW'(32'h0028BE53);
      5'd9:  r = ZW'(32'h00145F2F);
      5'd10: r = ZW'(32'h000A2F98);
      5'd11: r = ZW'(32'h000517CC);
      5'd12: r = ZW'(32'h00028BE6);
      5'd13: r = ZW'(32'h000145F3);
      5'd14: r = ZW'(32'h0000A2F9);
      5'd15: r = ZW'(32'h0000517C);
      5'd16: r = ZW'(32'h000028BE);
      5'd17: r = ZW'(32'h0000145F);
      5'd18: r = ZW'(32'h00000A2F);
      5'd19: r = ZW'(32'h00000517);
      5'd20: r = ZW'(32'h0000028B);
      5'd21: r = ZW'(32'h00000145);
      5'd22: r = ZW'(32'h000000A2);
      5'd23: r = ZW'(32'h00000051);
      default: r = '0;
    endcase
    return r;
  endfunction

  // q1.30 product, rounded, floor shift
  function automatic cval_t mulq(input cval_t a, input cval_t b);
    logic signed [ProdW-1:0] p;
    p = ProdW'(a) * ProdW'(b) + (ProdW'(1) <<< 29);
    return CordW'(p >>> 30);
  endfunction

  // round q1.30 term to q1.F and saturate to +-2^F
  function automatic logic [CoefBits-1:0] to_coef(input sval_t v);
    sval_t q;
    sval_t lim;
    q   = (v + (SumW'(1) <<< (29 - CoefF))) >>> (30 - CoefF);
    lim = SumW'(1) <<< CoefF;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q[CoefBits-1:0];
  endfunction
endpackage
`default_nettype wire

[hw/rtl/euler_pose_to_transform.sv]
// ----------------------------------------------------------------------------
// euler_pose_to_transform
// pose (position plus yaw, pitch, roll) to rigid transform R = Ry*Rx*Rz | t
// ----------------------------------------------------------------------------
// One request enters per cycle while the output side does not stall, and the
// matching results leave in order of arrival. The pipeline holds the 24 cordic
// iteration stages plus one input stage, then two product stages, one sum
// stage and one rounding stage. The whole pipeline advances as one unit when
// the output register is free or being read, so a stall holds every stage in
// place.
`default_nettype none
module euler_pose_to_transform (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output      logic         s_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], angle_x[111:96],
  // angle_y[127:112], angle_z[143:128]
  input  wire logic [143:0] s_tdata,
  output      logic         m_tvalid,
  input  wire logic         m_tready,
  // r00..r22 in [143:0] (16 bits each, r00 lowest), trans_x[175:144],
  // trans_y[207:176], trans_z[239:208]
  output      logic [239:0] m_tdata
);
  import ep2t_pkg::*;

  localparam int Lat = CordSteps + 5;   // stages from accept to output reg

  logic adv;
  logic [Lat-1:0] vld;
  logic [3*PosBits-1:0] pos_d [CordSteps+4];

  // whole pipe moves when output register can take a value
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Lat-2:0], s_tvalid};
    end
  end
  assign m_tvalid = vld[Lat-1];

  // translation rides alongside the angles
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_d[0] <= s_tdata[3*PosBits-1:0];
      for (int k = 1; k < CordSteps + 4; k++) pos_d[k] <= pos_d[k-1];
    end
  end

  cval_t sx, cx, sy, cy, sz, cz;

  ep2t_cordic u_cx (.clk(clk), .en(adv), .angle(s_tdata[111:96]),  .sin_q(sx), .cos_q(cx));
  ep2t_cordic u_cy (.clk(clk), .en(adv), .angle(s_tdata[127:112]), .sin_q(sy), .cos_q(cy));
  ep2t_cordic u_cz (.clk(clk), .en(adv), .angle(s_tdata[143:128]), .sin_q(sz), .cos_q(cz));

  // stage a: pair products
  cval_t sysx, cysx, cycz, cysz, sycz, sysz, sycx, cxsz, cxcz, cycx, nsx, sza, cza;
  always_ff @(posedge clk) begin
    if (adv) begin
      sysx <= mulq(sy, sx);
      cysx <= mulq(cy, sx);
      cycz <= mulq(cy, cz);
      cysz <= mulq(cy, sz);
      sycz <= mulq(sy, cz);
      sysz <= mulq(sy, sz);
      sycx <= mulq(sy, cx);
      cxsz <= mulq(cx, sz);
      cxcz <= mulq(cx, cz);
      cycx <= mulq(cy, cx);
      nsx  <= -sx;
      sza  <= sz;
      cza  <= cz;
    end
  end

  // stage b: triple products
  cval_t t00, t01, t20, t21;
  cval_t b_cycz, b_cysz, b_sycz, b_sysz, b_sycx, b_cxsz, b_cxcz, b_cycx, b_nsx;
  always_ff @(posedge clk) begin
    if (adv) begin
      t00 <= mulq(sysx, sza);
      t01 <= mulq(sysx, cza);
      t20 <= mulq(cysx, sza);
      t21 <= mulq(cysx, cza);
      b_cycz <= cycz; b_cysz <= cysz; b_sycz <= sycz; b_sysz <= sysz;
      b_sycx <= sycx; b_cxsz <= cxsz; b_cxcz <= cxcz; b_cycx <= cycx;
      b_nsx  <= nsx;
    end
  end

  // stage c: sums
  sval_t s0, s1, s2, s3, s4, s5, s6, s7, s8;
  always_ff @(posedge clk) begin
    if (adv) begin
      s0 <= SumW'(b_cycz) + SumW'(t00);
      s1 <= SumW'(t01) - SumW'(b_cysz);
      s2 <= SumW'(b_sycx);
      s3 <= SumW'(b_cxsz);
      s4 <= SumW'(b_cxcz);
      s5 <= SumW'(b_nsx);
      s6 <= SumW'(t20) - SumW'(b_sycz);
      s7 <= SumW'(b_sysz) + SumW'(t21);
      s8 <= SumW'(b_cycx);
    end
  end

  // output register: round and saturate
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {pos_d[CordSteps+3],
                  to_coef(s8), to_coef(s7), to_coef(s6), to_coef(s5), to_coef(s4),
                  to_coef(s3), to_coef(s2), to_coef(s1), to_coef(s0)};
    end
  end

  // stalled result must hold
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed under stall");
  // input is refused exactly while a result waits
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready out of step with output");
  // a fresh result needs a valid item in the stage ahead of the output register
  a_lat: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(vld[Lat-2]))
    else $error("result without source");
endmodule
`default_nettype wire

[hw/rtl/ep2t_cordic.sv]
// ----------------------------------------------------------------------------
// ep2t_cordic
// pipelined cordic rotator, one iteration per stage, sine and cosine q1.30
// ----------------------------------------------------------------------------
`default_nettype none
module ep2t_cordic (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [ep2t_pkg::AngleBits-1:0]   angle,
  output      ep2t_pkg::cval_t                  sin_q,
  output      ep2t_pkg::cval_t                  cos_q
);
  import ep2t_pkg::*;

  cval_t x [CordSteps+1];
  cval_t y [CordSteps+1];
  zval_t z [CordSteps+1];
  logic  flip [CordSteps+1];

  logic [31:0] a0;
  logic [31:0] a1;
  logic        fl0;

  always_comb begin
    a0  = {angle, {(32-AngleBits){1'b0}}};
    fl0 = (a0[31:30] == 2'b01) || (a0[31:30] == 2'b10);
    a1  = fl0 ? a0 + 32'h80000000 : a0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= CordGain;
      y[0]    <= '0;
      z[0]    <= ZW'(signed'(a1));
      flip[0] <= fl0;
    end
  end

  for (genvar i = 0; i < CordSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_tab(5'(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_tab(5'(i));
        end
      end
    end
  end

  assign sin_q = flip[CordSteps] ? -y[CordSteps] : y[CordSteps];
  assign cos_q = flip[CordSteps] ? -x[CordSteps] : x[CordSteps];
endmodule
`default_nettype wire

[test/tb_euler_pose_to_transform_chk.sv]
// ----------------------------------------------------------------------------
// tb_euler_pose_to_transform_chk
// watches both streams, predicts each transform and compares it field by field
// ----------------------------------------------------------------------------
`default_nettype none
module tb_euler_pose_to_transform_chk (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [143:0] s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [239:0] m_tdata,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Gain = 64'sd652032874;

  longint atan_q30 [24] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
    'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051};

  logic [239:0] transform_q[$];

  function automatic longint rnd30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // 16-bit binary angle to q1.30 sine and cosine
  function automatic void sincos(logic [15:0] ang, output longint s, output longint c);
    logic [31:0] turn;
    logic        flip;
    longint      x, y, z, dx, dy;
    turn = {ang, 16'h0};
    flip = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
    if (flip) turn = turn + 32'h80000000;
    z = longint'($signed(turn));
    x = Gain;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q30[i];
      end else begin
        x += dx; y -= dy; z += atan_q30[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic logic [15:0] coef(longint v);
    longint q;
    q = (v + (64'sd1 <<< 15)) >>> 16;
    if (q > 16384) q = 16384;
    if (q < -16384) q = -16384;
    return q[15:0];
  endfunction

  function automatic logic [239:0] pose_transform(logic [143:0] d);
    longint sx, cx, sy, cy, sz, cz, sysx, cysx;
    logic [239:0] r;
    sincos(d[111:96], sx, cx);
    sincos(d[127:112], sy, cy);
    sincos(d[143:128], sz, cz);
    sysx = rnd30(sy, sx);
    cysx = rnd30(cy, sx);
    r[15:0]    = coef(rnd30(cy, cz) + rnd30(sysx, sz));
    r[31:16]   = coef(-rnd30(cy, sz) + rnd30(sysx, cz));
    r[47:32]   = coef(rnd30(sy, cx));
    r[63:48]   = coef(rnd30(cx, sz));
    r[79:64]   = coef(rnd30(cx, cz));
    r[95:80]   = coef(-sx);
    r[111:96]  = coef(-rnd30(sy, cz) + rnd30(cysx, sz));
    r[127:112] = coef(rnd30(sy, sz) + rnd30(cysx, cz));
    r[143:128] = coef(rnd30(cy, cx));
    r[239:144] = d[95:0];
    return r;
  endfunction

  assign pending = transform_q.size();

  always @(posedge clk) begin
    logic [239:0] want;
    int           errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) transform_q.push_back(pose_transform(s_tdata));
      if (m_tvalid && m_tready) begin
        if (transform_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_tdata);
          errs++;
        end else begin
          want = transform_q.pop_front();
          for (int f = 0; f < 9; f++)
            if (m_tdata[f*16 +: 16] !== want[f*16 +: 16]) begin
              $display("%0t: r%0d%0d expected %0d actual %0d", $time, f / 3, f % 3,
                       $signed(want[f*16 +: 16]), $signed(m_tdata[f*16 +: 16]));
              errs++;
            end
          for (int f = 0; f < 3; f++)
            if (m_tdata[144 + f*32 +: 32] !== want[144 + f*32 +: 32]) begin
              $display("%0t: trans %0d expected %h actual %h", $time, f,
                       want[144 + f*32 +: 32], m_tdata[144 + f*32 +: 32]);
              errs++;
            end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule
`default_nettype wire

[test/tb_euler_pose_to_transform.sv]
// ----------------------------------------------------------------------------
// tb_euler_pose_to_transform
// directed and random poses through the transform pipeline with bursty input
// and a stalling receiver; a side checker predicts and compares every result
// ----------------------------------------------------------------------------
`default_nettype none
module tb_euler_pose_to_transform;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [239:0] m_tdata;
  int           fail_count;
  int           pending;

  euler_pose_to_transform DUT (.*);
  tb_euler_pose_to_transform_chk u_chk (.*);

  initial forever #2 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb_euler_pose_to_transform: FAIL");
    $finish;
  end

  // receiver stall pattern: modes of always ready, sparse and long stalls
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 15) != 0);
        endcase
      end
    end
  end

  logic [143:0] pose_q[$];
  logic [15:0]  angle_pick[14] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF,
                                   16'h8001, 16'h3FFF, 16'hBFFF, 16'h4001, 16'hC001,
                                   16'hFFFF, 16'h0001, 16'h2000, 16'hE000};

  function automatic logic [15:0] rand_angle();
    return ($urandom_range(0, 3) == 0) ? angle_pick[$urandom_range(0, 13)]
                                       : 16'($urandom);
  endfunction

  initial begin
    int burst;
    logic [143:0] p;
    // directed: position extremes and quadrant edges on each axis
    pose_q.push_back({16'h0, 16'h0, 16'h0, 32'h80000000, 32'h7FFFFFFF, 32'h0});
    pose_q.push_back({16'h0, 16'h0, 16'h0, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF});
    for (int k = 0; k < 14; k++)
      pose_q.push_back({angle_pick[k], angle_pick[(k + 5) % 14], angle_pick[(k + 9) % 14],
                        32'($urandom), 32'($urandom), 32'($urandom)});
    // gimbal lock: pitch at plus and minus a quarter turn
    pose_q.push_back({16'h1234, 16'h5678, 16'h4000, 96'h0});
    pose_q.push_back({16'h9ABC, 16'hDEF0, 16'hC000, 96'h0});
    // half turn on all three
    pose_q.push_back({16'h8000, 16'h8000, 16'h8000, 96'h0});
    for (int k = 0; k < 1950; k++) begin
      p = {rand_angle(), rand_angle(), rand_angle(), 32'($urandom), 32'($urandom),
           32'($urandom)};
      pose_q.push_back(p);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pose_q.size() > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && pose_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pose_q[0];
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        void'(pose_q.pop_front());
        burst--;
      end
      if (pose_q.size() > 0 && $urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_euler_pose_to_transform: PASS");
    else
      $display("tb_euler_pose_to_transform: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
hw/rtl/ep2t_pkg.sv
hw/rtl/ep2t_cordic.sv
hw/rtl/euler_pose_to_transform.sv
test/tb_euler_pose_to_transform_chk.sv
test/tb_euler_pose_to_transform.sv
